// File: sv/sql_keyword_tokenizer_macros.svh
`ifndef SQL_KEYWORD_TOKENIZER_MACROS_SVH
`define SQL_KEYWORD_TOKENIZER_MACROS_SVH

// same-cycle implication
`define SKL_ASSERT_NOW(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define SKL_ASSERT_NEXT(label, clk, rstn, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: sv/skl_pkg.sv
package skl_pkg;

    localparam int POSITION_WIDTH = 16;
    localparam int LENGTH_WIDTH   = 8;
    localparam int KIND_WIDTH     = 4;
    localparam int KW_COUNT       = 5;
    localparam int KW_MAX_LEN     = 6;
    localparam int SKL_QUEUE_DEPTH = 4;

    localparam logic [POSITION_WIDTH-1:0] POS_MAX = {POSITION_WIDTH{1'b1}};
    localparam logic [LENGTH_WIDTH-1:0]   LEN_MAX = {LENGTH_WIDTH{1'b1}};

    localparam logic [KIND_WIDTH-1:0] KIND_IDENT  = 4'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_STAR   = 4'd6;
    localparam logic [KIND_WIDTH-1:0] KIND_COMMA  = 4'd7;
    localparam logic [KIND_WIDTH-1:0] KIND_LPAREN = 4'd8;
    localparam logic [KIND_WIDTH-1:0] KIND_RPAREN = 4'd9;
    localparam logic [KIND_WIDTH-1:0] KIND_BAD    = 4'd10;
    localparam logic [KIND_WIDTH-1:0] KIND_EOF    = 4'd11;

    localparam logic OP_CHAR = 1'b0;
    localparam logic OP_END  = 1'b1;

    localparam logic [7:0] CH_STAR    = 8'h2A;
    localparam logic [7:0] CH_COMMA   = 8'h2C;
    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_NEWLINE = 8'h0A;
    localparam logic [7:0] CH_SPACE   = 8'h20;

    // select, from, as, create, table
    localparam logic [7:0] KW_TEXT [KW_COUNT][KW_MAX_LEN] = '{
        '{8'h73, 8'h65, 8'h6C, 8'h65, 8'h63, 8'h74},
        '{8'h66, 8'h72, 8'h6F, 8'h6D, 8'h00, 8'h00},
        '{8'h61, 8'h73, 8'h00, 8'h00, 8'h00, 8'h00},
        '{8'h63, 8'h72, 8'h65, 8'h61, 8'h74, 8'h65},
        '{8'h74, 8'h61, 8'h62, 8'h6C, 8'h65, 8'h00}
    };
    localparam logic [2:0] KW_LEN [KW_COUNT] = '{3'd6, 3'd4, 3'd2, 3'd6, 3'd5};

    typedef struct packed {
        logic       operation;
        logic [7:0] char_code;
    } in_word_t;

    typedef struct packed {
        logic [KIND_WIDTH-1:0]     token_kind;
        logic [POSITION_WIDTH-1:0] line_number;
        logic [POSITION_WIDTH-1:0] start_offset;
        logic [LENGTH_WIDTH-1:0]   lexeme_length;
        logic                      last_of_run;
    } out_word_t;

    typedef struct packed {
        logic [KIND_WIDTH-1:0]     kind;
        logic [POSITION_WIDTH-1:0] line;
        logic [POSITION_WIDTH-1:0] start;
        logic [LENGTH_WIDTH-1:0]   len;
    } tok_t;

    // first token always valid; second optional
    typedef struct packed {
        tok_t first;
        logic second_vld;
        tok_t second;
    } job_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } q_stat_t;

endpackage

// File: sv/skl_front.sv
module skl_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  skl_pkg::in_word_t s_word,
    input  skl_pkg::q_stat_t q_stat,
    output logic             push,
    output skl_pkg::job_t    push_job
);
    import skl_pkg::*;

    logic                      in_word_reg, in_word_next;
    logic [POSITION_WIDTH-1:0] word_start_reg, word_start_next;
    logic [LENGTH_WIDTH-1:0]   word_length_reg, word_length_next;
    logic [KW_COUNT-1:0]       kw_alive_reg, kw_alive_next;
    logic [POSITION_WIDTH-1:0] line_count_reg, line_count_next;
    logic [POSITION_WIDTH-1:0] byte_pos_reg, byte_pos_next;

    logic                    accept;
    logic                    is_letter, is_blank, has_sym;
    logic [KIND_WIDTH-1:0]   word_kind, sym_kind;
    logic [KW_COUNT-1:0]     alive_base;
    logic [LENGTH_WIDTH-1:0] len_base;
    tok_t                    word_tok, sym_tok;

    assign s_ready = !q_stat.full;
    assign accept  = s_valid && s_ready;

    always_comb begin
        is_letter = (s_word.operation == OP_CHAR) &&
                    (s_word.char_code inside {[8'h41:8'h5A], [8'h61:8'h7A]});
        is_blank  = (s_word.char_code == CH_SPACE) ||
                    (s_word.char_code inside {[8'h09:8'h0D]});
        case (s_word.char_code)
            CH_STAR:   sym_kind = KIND_STAR;
            CH_COMMA:  sym_kind = KIND_COMMA;
            CH_LPAREN: sym_kind = KIND_LPAREN;
            CH_RPAREN: sym_kind = KIND_RPAREN;
            default:   sym_kind = KIND_BAD;
        endcase
        if (s_word.operation == OP_END) begin
            sym_kind = KIND_EOF;
        end
        has_sym = (s_word.operation == OP_END) || (!is_letter && !is_blank);
    end

    // keyword lookup on the pending word, lowest index wins
    always_comb begin
        word_kind = KIND_IDENT;
        for (int i = KW_COUNT - 1; i >= 0; i--) begin
            if (kw_alive_reg[i] && word_length_reg == LENGTH_WIDTH'(KW_LEN[i])) begin
                word_kind = KIND_WIDTH'(i + 1);
            end
        end
    end

    always_comb begin
        word_tok.kind  = word_kind;
        word_tok.line  = line_count_reg;
        word_tok.start = word_start_reg;
        word_tok.len   = word_length_reg;
        sym_tok.kind   = sym_kind;
        sym_tok.line   = line_count_reg;
        sym_tok.start  = byte_pos_reg;
        sym_tok.len    = (s_word.operation == OP_END) ? '0 : LENGTH_WIDTH'(1);

        push_job.first      = in_word_reg ? word_tok : sym_tok;
        push_job.second_vld = in_word_reg && has_sym;
        push_job.second     = sym_tok;
        push = accept && !is_letter && (in_word_reg || has_sym);
    end

    always_comb begin
        in_word_next     = in_word_reg;
        word_start_next  = word_start_reg;
        word_length_next = word_length_reg;
        kw_alive_next    = kw_alive_reg;
        line_count_next  = line_count_reg;
        byte_pos_next    = byte_pos_reg;
        alive_base       = in_word_reg ? kw_alive_reg : '1;
        len_base         = in_word_reg ? word_length_reg : '0;
        if (accept) begin
            if (s_word.operation == OP_END) begin
                in_word_next     = 1'b0;
                word_start_next  = '0;
                word_length_next = '0;
                kw_alive_next    = '1;
                line_count_next  = POSITION_WIDTH'(1);
                byte_pos_next    = '0;
            end else begin
                if (is_letter) begin
                    in_word_next = 1'b1;
                    if (!in_word_reg) begin
                        word_start_next = byte_pos_reg;
                    end
                    for (int i = 0; i < KW_COUNT; i++) begin
                        kw_alive_next[i] = alive_base[i] &&
                            (len_base < LENGTH_WIDTH'(KW_LEN[i])) &&
                            (KW_TEXT[i][len_base[2:0]] == s_word.char_code);
                    end
                    word_length_next = (len_base < LEN_MAX) ? len_base + 1'b1 : len_base;
                end else begin
                    in_word_next     = 1'b0;
                    word_length_next = '0;
                    kw_alive_next    = '1;
                    if (s_word.char_code == CH_NEWLINE && line_count_reg < POS_MAX) begin
                        line_count_next = line_count_reg + 1'b1;
                    end
                end
                if (byte_pos_reg < POS_MAX) begin
                    byte_pos_next = byte_pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_word_reg     <= 1'b0;
            word_start_reg  <= '0;
            word_length_reg <= '0;
            kw_alive_reg    <= '1;
            line_count_reg  <= POSITION_WIDTH'(1);
            byte_pos_reg    <= '0;
        end else begin
            in_word_reg     <= in_word_next;
            word_start_reg  <= word_start_next;
            word_length_reg <= word_length_next;
            kw_alive_reg    <= kw_alive_next;
            line_count_reg  <= line_count_next;
            byte_pos_reg    <= byte_pos_next;
        end
    end

endmodule

// File: sv/skl_queue.sv
module skl_queue #(
    parameter int DEPTH = skl_pkg::SKL_QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  skl_pkg::job_t    push_job,
    input  logic             pop,
    output skl_pkg::job_t    pop_job,
    output skl_pkg::q_stat_t q_stat
);
    import skl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign q_stat.not_empty = (count_reg != '0);
    assign q_stat.full      = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !q_stat.full;
    assign do_pop  = pop && q_stat.not_empty;
    assign pop_job = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// File: sv/skl_back.sv
module skl_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  skl_pkg::q_stat_t  q_stat,
    input  skl_pkg::job_t     pop_job,
    output logic              pop,
    output logic              m_valid,
    input  logic              m_ready,
    output skl_pkg::out_word_t m_word
);
    import skl_pkg::*;

    logic      m_valid_reg, m_valid_next;
    out_word_t m_word_reg, m_word_next;
    logic      pend_reg, pend_next;
    tok_t      hold_reg, hold_next;
    logic      out_free;

    function automatic out_word_t to_word(input tok_t t, input logic last);
        out_word_t w;
        w.token_kind    = t.kind;
        w.line_number   = t.line;
        w.start_offset  = t.start;
        w.lexeme_length = t.len;
        w.last_of_run   = last;
        return w;
    endfunction

    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_word   = m_word_reg;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_word_next  = m_word_reg;
        pend_next    = pend_reg;
        hold_next    = hold_reg;
        pop          = 1'b0;
        if (out_free) begin
            if (pend_reg) begin
                m_valid_next = 1'b1;
                m_word_next  = to_word(hold_reg, 1'b1);
                pend_next    = 1'b0;
            end else if (q_stat.not_empty) begin
                pop          = 1'b1;
                m_valid_next = 1'b1;
                m_word_next  = to_word(pop_job.first, !pop_job.second_vld);
                pend_next    = pop_job.second_vld;
                hold_next    = pop_job.second;
            end else begin
                m_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_word_reg <= m_word_next;
        hold_reg   <= hold_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            pend_reg    <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
            pend_reg    <= pend_next;
        end
    end

endmodule

// File: sv/sql_keyword_tokenizer.sv
// channel | dir | handshake         | word
// s_      | in  | s_valid / s_ready | operation, char_code
// m_      | out | m_valid / m_ready | token_kind, line_number, start_offset,
//         |     |                   | lexeme_length, last_of_run
// One input word per cycle while s_ready is high; each makes 0 to 2 tokens,
// emitted 1 per cycle while m_ready is high. A job is registered in the queue,
// then in m_word_reg; the back end's one token per cycle bounds the rate.
// Reset: synchronous active-low aresetn; counters to line 1, offset 0.
// s_ready drops only while the job queue is full; m_ready stalls hold m_word.
module sql_keyword_tokenizer #(
    parameter int QUEUE_DEPTH = skl_pkg::SKL_QUEUE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  skl_pkg::in_word_t  s_word,
    output logic               m_valid,
    input  logic               m_ready,
    output skl_pkg::out_word_t m_word
);
    import skl_pkg::*;

    q_stat_t q_stat;
    logic    push, pop;
    job_t    push_job, pop_job;

    skl_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_word   (s_word),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    skl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .q_stat   (q_stat)
    );

    skl_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_stat  (q_stat),
        .pop_job (pop_job),
        .pop     (pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_word  (m_word)
    );

endmodule

// File: sv/skl_checker.sv
`include "sql_keyword_tokenizer_macros.svh"

module skl_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               m_valid,
    input logic               m_ready,
    input skl_pkg::out_word_t m_word
);
    import skl_pkg::*;

    logic sym_tok;
    logic sym_len_ok;
    logic eof_tok;
    logic eof_ok;
    assign sym_tok = (m_word.token_kind == KIND_STAR) || (m_word.token_kind == KIND_COMMA) ||
                     (m_word.token_kind == KIND_LPAREN) || (m_word.token_kind == KIND_RPAREN) ||
                     (m_word.token_kind == KIND_BAD);
    assign sym_len_ok = (m_word.lexeme_length == LENGTH_WIDTH'(1));
    assign eof_tok    = (m_word.token_kind == KIND_EOF);
    assign eof_ok     = m_word.last_of_run && (m_word.lexeme_length == '0);

    `SKL_ASSERT_NEXT(a_m_valid_holds, aclk, aresetn, m_valid && !m_ready, m_valid, "m_valid dropped")
    `SKL_ASSERT_NEXT(a_m_word_holds, aclk, aresetn, m_valid && !m_ready, $stable(m_word), "m_word moved")
    `SKL_ASSERT_NOW(a_sym_len, aclk, aresetn, m_valid && sym_tok, sym_len_ok, "symbol length")
    `SKL_ASSERT_NOW(a_eof_last, aclk, aresetn, m_valid && eof_tok, eof_ok, "eof token")
    `SKL_ASSERT_NOW(a_line_nz, aclk, aresetn, m_valid, m_word.line_number != '0, "line zero")

endmodule

bind sql_keyword_tokenizer skl_checker u_skl_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_word  (m_word)
);
